// ===== hdl/mhm_pkg.sv =====
`timescale 1ns / 1ps

package mhm_pkg;

   localparam int ACC_W = 52;

   localparam logic [1:0] OP_TRIAL  = 2'd0;
   localparam logic [1:0] OP_COMMIT = 2'd1;
   localparam logic [1:0] OP_REVERT = 2'd2;
   localparam logic [1:0] OP_START  = 2'd3;

   localparam logic [3:0] CSR_STRAIN_1 = 4'd0;
   localparam logic [3:0] CSR_STRESS_1 = 4'd4;
   localparam logic [3:0] CSR_END      = 4'd8;

   localparam logic [5:0] DIV_STEPS = 6'd47;

   // boot values of the breakpoints, row 3 first in the list and row 0 last
   localparam logic [3:0][30:0] RST_STRAIN = {31'd262144, 31'd196608, 31'd131072, 31'd65536};
   localparam logic [3:0][30:0] RST_STRESS = {31'd1310720, 31'd1179648, 31'd983040, 31'd655360};

   typedef struct packed {
      logic signed [31:0] neg_e;
      logic signed [31:0] pos_e;
      logic signed [31:0] neg_s;
      logic signed [31:0] pos_s;
      logic signed [31:0] slope;
      logic signed [31:0] span;
   } row_type;

   function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
      logic signed [31:0] r;
      if (v > 52'sd2147483647) r = 32'sh7fffffff;
      else if (v < -52'sd2147483648) r = 32'sh80000000;
      else r = v[31:0];
      return r;
   endfunction

endpackage

// ===== hdl/multilinear_hysteretic_material.sv =====
`timescale 1ns / 1ps

// channel  | dir | ports                               | content
// req      | in  | req_tvalid/tready/tdata/tuser       | tdata: new_strain; tuser: opcode
// rsp      | out | rsp_tvalid/tready/tdata             | stress, tangent, strain, segment
// csr      | in  | csr_valid/ready/index/data          | breakpoint register write
//
// Trial strain: the table rows are searched in turn, then the product is formed in the
// shared 18x32 multiplier (MUL_LO, MUL_HI, MUL_ACC). Unchanged strain, elastic commit
// and revert to last commit go straight to the response. Commit after yield rewrites
// every row in turn. Revert to start runs the bit-serial slope divider for every row
// (skipped for a zero span); after reset the table is built likewise, req_tready low.
// A result waiting on rsp_tready stalls the next word at its final step only.
module multilinear_hysteretic_material #(
   parameter int NUM_SEGMENTS = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [31:0]  req_tdata,   // [31:0] new_strain
   input  logic [1:0]   req_tuser,   // [1:0] opcode
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [103:0] rsp_tdata,   // stress_out, tangent_out, strain_out, segment_out, pad
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [3:0]   csr_index,
   input  logic [30:0]  csr_data
);
   import mhm_pkg::*;

   localparam int IDX_W = (NUM_SEGMENTS > 1) ? $clog2(NUM_SEGMENTS) : 1;
   localparam logic [2:0] LAST_IDX = 3'(NUM_SEGMENTS - 1);

   typedef enum logic [3:0] {
      ST_IDLE, ST_T_RD, ST_T_CHK, ST_C_RD, ST_C_FAR, ST_C_WR,
      ST_B_ROW, ST_DIV, ST_DIV_END, ST_B_WR,
      ST_MUL_LO, ST_MUL_HI, ST_MUL_ACC, ST_DONE
   } state_type;

   state_type state_ff;

   row_type mem [NUM_SEGMENTS];
   row_type rd_row_ff, wr_row_ff;
   logic [IDX_W-1:0] rd_addr_ff;
   logic wr_en;

   logic [30:0] cfg_strain_ff [4];
   logic [30:0] cfg_stress_ff [4];

   logic signed [31:0] trial_strain_ff, trial_stress_ff, trial_tangent_ff;
   logic [1:0]         trial_segment_ff, seg_ff;
   logic signed [31:0] committed_strain_ff, committed_stress_ff, committed_tangent_ff;
   logic signed [31:0] slope0_ff;

   logic [2:0] idx_ff;
   logic       side_ff, boot_ff, ret_commit_ff;
   logic signed [31:0] prev_far_e_ff, prev_far_s_ff, prev_near_e_ff;
   logic [30:0] pe_ff, ps_ff;

   logic [33:0] mul_ua_ff;
   logic [31:0] mul_ub_ff;
   logic        mul_neg_ff;
   logic signed [31:0] mul_base_ff;
   logic [49:0] m_ff;
   logic [17:0] mul_x;
   logic [49:0] mul_p;
   logic signed [ACC_W-1:0] mul_mag, mul_sum;

   logic [30:0] div_rem_ff, div_den_ff;
   logic [46:0] div_quo_ff;
   logic        div_neg_ff;
   logic [5:0]  div_cnt_ff;
   logic [31:0] div_try;

   logic        rsp_tvalid_ff;
   logic [103:0] rsp_tdata_ff;

   // trial search
   logic signed [31:0] t;
   logic in_el, chk_side, chk_cond;
   logic signed [33:0] trial_a;

   // commit row update
   logic side_c, low_seg;
   logic signed [31:0] near_old, near_s_old, near_new, near_s_new, far_e_new;
   logic signed [33:0] span2, commit_a;
   logic signed [35:0] far_sum;
   row_type c_row;

   // rebuild
   logic [30:0] b_e, b_s;
   logic signed [31:0] b_de, b_ds;

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign wr_en      = (state_ff == ST_C_WR) || (state_ff == ST_B_WR);

   always_ff @(posedge clock) begin
      if (wr_en) mem[idx_ff[IDX_W-1:0]] <= wr_row_ff;
      rd_row_ff <= mem[rd_addr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) begin
            cfg_strain_ff[i] <= RST_STRAIN[i];
            cfg_stress_ff[i] <= RST_STRESS[i];
         end
      end else if (csr_valid) begin
         if (csr_index < CSR_STRESS_1) cfg_strain_ff[csr_index[1:0]] <= csr_data;
         else if (csr_index < CSR_END) cfg_stress_ff[csr_index[1:0]] <= csr_data;
      end
   end

   always_comb begin
      t        = trial_strain_ff;
      in_el    = (t >= rd_row_ff.neg_e) && (t <= rd_row_ff.pos_e);
      chk_side = (idx_ff == 3'd0) ? (!in_el && (t > rd_row_ff.pos_e)) : side_ff;
      chk_cond = side_ff ? (t > rd_row_ff.pos_e) : (t < rd_row_ff.neg_e);
      trial_a  = {{2{t[31]}}, t} -
                 (chk_side ? {{2{rd_row_ff.pos_e[31]}}, rd_row_ff.pos_e}
                           : {{2{rd_row_ff.neg_e[31]}}, rd_row_ff.neg_e});

      side_c     = (idx_ff == 3'd0) ? (t > rd_row_ff.pos_e) : side_ff;
      low_seg    = idx_ff < {1'b0, seg_ff};
      near_old   = side_c ? rd_row_ff.pos_e : rd_row_ff.neg_e;
      near_s_old = side_c ? rd_row_ff.pos_s : rd_row_ff.neg_s;
      span2      = {rd_row_ff.span[31], rd_row_ff.span, 1'b0};
      far_sum    = {{4{prev_far_e_ff[31]}}, prev_far_e_ff} +
                   (side_c ? -{{2{span2[33]}}, span2} : {{2{span2[33]}}, span2});
      if (!low_seg)
         far_sum = far_sum + {{4{near_old[31]}}, near_old} -
                   {{4{prev_near_e_ff[31]}}, prev_near_e_ff};
      far_e_new  = sat32({{16{far_sum[35]}}, far_sum});
      near_new   = low_seg ? trial_strain_ff : near_old;
      near_s_new = low_seg ? trial_stress_ff : near_s_old;
      commit_a   = low_seg ? span2 : ({{2{far_e_new[31]}}, far_e_new} -
                                      {{2{prev_far_e_ff[31]}}, prev_far_e_ff});

      c_row = rd_row_ff;
      if (side_c) begin
         c_row.pos_e = near_new;
         c_row.pos_s = near_s_new;
         c_row.neg_e = far_e_new;
      end else begin
         c_row.neg_e = near_new;
         c_row.neg_s = near_s_new;
         c_row.pos_e = far_e_new;
      end

      b_e  = boot_ff ? RST_STRAIN[idx_ff[1:0]] : cfg_strain_ff[idx_ff[1:0]];
      b_s  = boot_ff ? RST_STRESS[idx_ff[1:0]] : cfg_stress_ff[idx_ff[1:0]];
      b_de = $signed({1'b0, b_e}) - $signed({1'b0, pe_ff});
      b_ds = $signed({1'b0, b_s}) - $signed({1'b0, ps_ff});

      div_try = {div_rem_ff, div_quo_ff[46]};

      mul_x   = (state_ff == ST_MUL_LO) ? {2'b0, mul_ua_ff[15:0]} : mul_ua_ff[33:16];
      mul_p   = mul_x * mul_ub_ff;
      mul_mag = {2'b0, m_ff};
      mul_sum = {{20{mul_base_ff[31]}}, mul_base_ff} + (mul_neg_ff ? -mul_mag : mul_mag);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff             <= ST_B_ROW;
         boot_ff              <= 1'b1;
         idx_ff               <= 3'd0;
         pe_ff                <= '0;
         ps_ff                <= '0;
         rd_addr_ff           <= '0;
         rsp_tvalid_ff        <= 1'b0;
         trial_strain_ff      <= '0;
         trial_stress_ff      <= '0;
         trial_segment_ff     <= '0;
         committed_strain_ff  <= '0;
         committed_stress_ff  <= '0;
      end else begin
         if (rsp_tvalid_ff && rsp_tready && (state_ff != ST_DONE)) rsp_tvalid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  idx_ff     <= 3'd0;
                  rd_addr_ff <= '0;
                  unique case (req_tuser)
                     OP_TRIAL: begin
                        if ($signed(req_tdata) == trial_strain_ff) state_ff <= ST_DONE;
                        else begin
                           trial_strain_ff <= req_tdata;
                           state_ff        <= ST_T_RD;
                        end
                     end
                     OP_COMMIT: begin
                        if (trial_segment_ff == 2'd0) begin
                           committed_strain_ff  <= trial_strain_ff;
                           committed_stress_ff  <= trial_stress_ff;
                           committed_tangent_ff <= trial_tangent_ff;
                           state_ff             <= ST_DONE;
                        end else begin
                           seg_ff         <= trial_segment_ff;
                           prev_far_e_ff  <= trial_strain_ff;
                           prev_far_s_ff  <= trial_stress_ff;
                           prev_near_e_ff <= trial_strain_ff;
                           state_ff       <= ST_C_RD;
                        end
                     end
                     OP_REVERT: begin
                        trial_strain_ff  <= committed_strain_ff;
                        trial_stress_ff  <= committed_stress_ff;
                        trial_tangent_ff <= committed_tangent_ff;
                        state_ff         <= ST_DONE;
                     end
                     default: begin
                        boot_ff  <= 1'b0;
                        pe_ff    <= '0;
                        ps_ff    <= '0;
                        state_ff <= ST_B_ROW;
                     end
                  endcase
               end
            end
            ST_T_RD: state_ff <= ST_T_CHK;
            ST_T_CHK: begin
               if ((idx_ff == 3'd0) && !in_el && (LAST_IDX != 3'd0)) begin
                  side_ff    <= t > rd_row_ff.pos_e;
                  idx_ff     <= 3'd1;
                  rd_addr_ff <= IDX_W'(1);
                  state_ff   <= ST_T_RD;
               end else if ((idx_ff != 3'd0) && chk_cond && (idx_ff != LAST_IDX)) begin
                  idx_ff     <= idx_ff + 3'd1;
                  rd_addr_ff <= IDX_W'(idx_ff + 3'd1);
                  state_ff   <= ST_T_RD;
               end else begin
                  trial_segment_ff <= idx_ff[1:0];
                  trial_tangent_ff <= rd_row_ff.slope;
                  mul_ua_ff   <= trial_a[33] ? 34'(-trial_a) : 34'(trial_a);
                  mul_ub_ff   <= rd_row_ff.slope[31] ? 32'(-rd_row_ff.slope)
                                                     : 32'(rd_row_ff.slope);
                  mul_neg_ff  <= trial_a[33] ^ rd_row_ff.slope[31];
                  mul_base_ff <= chk_side ? rd_row_ff.pos_s : rd_row_ff.neg_s;
                  ret_commit_ff <= 1'b0;
                  state_ff    <= ST_MUL_LO;
               end
            end
            ST_C_RD: state_ff <= ST_C_FAR;
            ST_C_FAR: begin
               side_ff        <= side_c;
               wr_row_ff      <= c_row;
               prev_near_e_ff <= near_new;
               prev_far_e_ff  <= far_e_new;
               mul_ua_ff   <= commit_a[33] ? 34'(-commit_a) : 34'(commit_a);
               mul_ub_ff   <= rd_row_ff.slope[31] ? 32'(-rd_row_ff.slope)
                                                  : 32'(rd_row_ff.slope);
               mul_neg_ff  <= commit_a[33] ^ rd_row_ff.slope[31] ^ (low_seg & side_c);
               mul_base_ff <= prev_far_s_ff;
               ret_commit_ff <= 1'b1;
               state_ff    <= ST_MUL_LO;
            end
            ST_C_WR: begin
               if (idx_ff == LAST_IDX) begin
                  committed_strain_ff  <= trial_strain_ff;
                  committed_stress_ff  <= trial_stress_ff;
                  committed_tangent_ff <= trial_tangent_ff;
                  state_ff             <= ST_DONE;
               end else begin
                  idx_ff     <= idx_ff + 3'd1;
                  rd_addr_ff <= IDX_W'(idx_ff + 3'd1);
                  state_ff   <= ST_C_RD;
               end
            end
            ST_MUL_LO: begin
               m_ff     <= {18'b0, mul_p[47:16]};
               state_ff <= ST_MUL_HI;
            end
            ST_MUL_HI: begin
               m_ff     <= m_ff + mul_p;
               state_ff <= ST_MUL_ACC;
            end
            ST_MUL_ACC: begin
               if (ret_commit_ff) begin
                  if (side_ff) wr_row_ff.neg_s <= sat32(mul_sum);
                  else wr_row_ff.pos_s <= sat32(mul_sum);
                  prev_far_s_ff <= sat32(mul_sum);
                  state_ff      <= ST_C_WR;
               end else begin
                  trial_stress_ff <= sat32(mul_sum);
                  state_ff        <= ST_DONE;
               end
            end
            ST_B_ROW: begin
               wr_row_ff.neg_e <= -$signed({1'b0, b_e});
               wr_row_ff.pos_e <= $signed({1'b0, b_e});
               wr_row_ff.neg_s <= -$signed({1'b0, b_s});
               wr_row_ff.pos_s <= $signed({1'b0, b_s});
               wr_row_ff.span  <= b_de;
               wr_row_ff.slope <= '0;
               pe_ff <= b_e;
               ps_ff <= b_s;
               div_quo_ff <= {(b_ds[31] ? 31'(-b_ds) : 31'(b_ds)), 16'b0};
               div_den_ff <= b_de[31] ? 31'(-b_de) : 31'(b_de);
               div_rem_ff <= '0;
               div_neg_ff <= b_ds[31] ^ b_de[31];
               div_cnt_ff <= '0;
               state_ff   <= (b_de == 32'sd0) ? ST_B_WR : ST_DIV;
            end
            ST_DIV: begin
               if (div_try >= {1'b0, div_den_ff}) begin
                  div_rem_ff <= 31'(div_try - {1'b0, div_den_ff});
                  div_quo_ff <= {div_quo_ff[45:0], 1'b1};
               end else begin
                  div_rem_ff <= div_try[30:0];
                  div_quo_ff <= {div_quo_ff[45:0], 1'b0};
               end
               div_cnt_ff <= div_cnt_ff + 6'd1;
               if (div_cnt_ff == DIV_STEPS - 6'd1) state_ff <= ST_DIV_END;
            end
            ST_DIV_END: begin
               if (div_neg_ff)
                  wr_row_ff.slope <= (div_quo_ff > 47'd2147483648) ? 32'sh80000000
                                                                 : 32'(47'd0 - div_quo_ff);
               else
                  wr_row_ff.slope <= (div_quo_ff > 47'd2147483647) ? 32'sh7fffffff
                                                                 : div_quo_ff[31:0];
               state_ff <= ST_B_WR;
            end
            ST_B_WR: begin
               if (idx_ff == 3'd0) slope0_ff <= wr_row_ff.slope;
               if (idx_ff == LAST_IDX) begin
                  trial_strain_ff      <= '0;
                  trial_stress_ff      <= '0;
                  committed_strain_ff  <= '0;
                  committed_stress_ff  <= '0;
                  trial_segment_ff     <= '0;
                  trial_tangent_ff     <= (idx_ff == 3'd0) ? wr_row_ff.slope : slope0_ff;
                  committed_tangent_ff <= (idx_ff == 3'd0) ? wr_row_ff.slope : slope0_ff;
                  idx_ff               <= 3'd0;
                  state_ff             <= boot_ff ? ST_IDLE : ST_DONE;
                  boot_ff              <= 1'b0;
               end else begin
                  idx_ff   <= idx_ff + 3'd1;
                  state_ff <= ST_B_ROW;
               end
            end
            ST_DONE: begin
               if (!rsp_tvalid_ff || rsp_tready) begin
                  rsp_tvalid_ff <= 1'b1;
                  rsp_tdata_ff  <= {6'b0, trial_segment_ff, trial_strain_ff,
                                    trial_tangent_ff, trial_stress_ff};
                  state_ff      <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

// ===== tb/mhm_checker.sv =====
`timescale 1ns / 1ps

module mhm_checker
   import mhm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [31:0]  req_tdata,
   input  logic [1:0]   req_tuser,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [103:0] rsp_tdata,
   input  logic         csr_valid,
   input  logic         csr_ready,
   input  logic [3:0]   csr_index,
   input  logic [30:0]  csr_data,
   output int           fail_count,
   output int           pending
);

   typedef struct {
      logic signed [31:0] stress;
      logic signed [31:0] tangent;
      logic signed [31:0] strain;
      logic [1:0]         segment;
   } material_word;

   localparam int NSEG = 4;

   logic [30:0] brk_strain [NSEG];
   logic [30:0] brk_stress [NSEG];

   longint neg_e [NSEG];
   longint pos_e [NSEG];
   longint neg_s [NSEG];
   longint pos_s [NSEG];
   longint slope [NSEG];
   longint span [NSEG];
   longint cur_strain, cur_stress, cur_tangent;
   longint held_strain, held_stress, held_tangent;
   int     cur_seg;

   material_word expected_words [$];

   function automatic longint clip32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // Q16.16 product, truncated toward zero
   function automatic longint qmul(longint a, longint b);
      logic neg;
      longint unsigned ua, ub, m;
      neg = (a < 0) != (b < 0);
      ua = a < 0 ? -a : a;
      ub = b < 0 ? -b : b;
      m = (ua >> 16) * ub + (((ua & 64'hffff) * ub) >> 16);
      return neg ? -longint'(m) : longint'(m);
   endfunction

   function automatic void build_table();
      longint pe, ps, e, s;
      pe = 0;
      ps = 0;
      for (int i = 0; i < NSEG; i++) begin
         e = longint'(brk_strain[i]);
         s = longint'(brk_stress[i]);
         neg_e[i] = clip32(-e);
         pos_e[i] = clip32(e);
         neg_s[i] = clip32(-s);
         pos_s[i] = clip32(s);
         span[i] = clip32(e - pe);
         slope[i] = (e == pe) ? 0 : clip32(((s - ps) * 65536) / (e - pe));
         pe = e;
         ps = s;
      end
      cur_strain = 0;
      cur_stress = 0;
      held_strain = 0;
      held_stress = 0;
      cur_tangent = slope[0];
      held_tangent = slope[0];
      cur_seg = 0;
   endfunction

   function automatic void take_strain(longint t);
      int k;
      if (t == cur_strain) return;
      cur_strain = t;
      if (t >= neg_e[0] && t <= pos_e[0]) begin
         cur_seg = 0;
         cur_tangent = slope[0];
         cur_stress = clip32(neg_s[0] + qmul(t - neg_e[0], slope[0]));
      end else if (t < neg_e[0]) begin
         k = 1;
         while (k < NSEG && t < neg_e[k]) k++;
         if (k >= NSEG) k = NSEG - 1;
         cur_seg = k;
         cur_tangent = slope[k];
         cur_stress = clip32(neg_s[k] + qmul(t - neg_e[k], cur_tangent));
      end else begin
         k = 1;
         while (k < NSEG && t > pos_e[k]) k++;
         if (k >= NSEG) k = NSEG - 1;
         cur_seg = k;
         cur_tangent = slope[k];
         cur_stress = clip32(pos_s[k] + qmul(t - pos_e[k], cur_tangent));
      end
   endfunction

   // after a yield, shift the yield surfaces so the far side trails the current point; then hold the state
   function automatic void commit_state();
      longint t, s, w;
      t = cur_strain;
      s = cur_stress;
      if (cur_seg != 0) begin
         w = 2 * span[0];
         if (t > pos_e[0]) begin
            pos_e[0] = t;
            pos_s[0] = s;
            neg_e[0] = clip32(t - w);
            neg_s[0] = clip32(s - qmul(w, slope[0]));
            for (int i = 1; i < NSEG; i++) begin
               w = 2 * span[i];
               if (i < cur_seg) begin
                  pos_e[i] = t;
                  pos_s[i] = s;
                  neg_e[i] = clip32(neg_e[i-1] - w);
                  neg_s[i] = clip32(neg_s[i-1] - qmul(w, slope[i]));
               end else begin
                  neg_e[i] = clip32(neg_e[i-1] - w + pos_e[i] - pos_e[i-1]);
                  neg_s[i] = clip32(neg_s[i-1] + qmul(neg_e[i] - neg_e[i-1], slope[i]));
               end
            end
         end else begin
            neg_e[0] = t;
            neg_s[0] = s;
            pos_e[0] = clip32(t + w);
            pos_s[0] = clip32(s + qmul(w, slope[0]));
            for (int i = 1; i < NSEG; i++) begin
               w = 2 * span[i];
               if (i < cur_seg) begin
                  neg_e[i] = t;
                  neg_s[i] = s;
                  pos_e[i] = clip32(pos_e[i-1] + w);
                  pos_s[i] = clip32(pos_s[i-1] + qmul(w, slope[i]));
               end else begin
                  pos_e[i] = clip32(pos_e[i-1] + w + neg_e[i] - neg_e[i-1]);
                  pos_s[i] = clip32(pos_s[i-1] + qmul(pos_e[i] - pos_e[i-1], slope[i]));
               end
            end
         end
      end
      held_strain = cur_strain;
      held_stress = cur_stress;
      held_tangent = cur_tangent;
   endfunction

   always @(posedge clock) begin
      material_word got, want;
      if (reset) begin
         for (int i = 0; i < NSEG; i++) begin
            brk_strain[i] = RST_STRAIN[i];
            brk_stress[i] = RST_STRESS[i];
         end
         build_table();
         expected_words.delete();
         fail_count = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.stress  = rsp_tdata[31:0];
            got.tangent = rsp_tdata[63:32];
            got.strain  = rsp_tdata[95:64];
            got.segment = rsp_tdata[97:96];
            if (expected_words.size() == 0) begin
               $error("unexpected response word");
               fail_count++;
            end else begin
               want = expected_words.pop_front();
               if (got.stress !== want.stress) begin
                  $error("stress_out: expected %0d, got %0d", want.stress, got.stress);
                  fail_count++;
               end
               if (got.tangent !== want.tangent) begin
                  $error("tangent_out: expected %0d, got %0d", want.tangent, got.tangent);
                  fail_count++;
               end
               if (got.strain !== want.strain) begin
                  $error("strain_out: expected %0d, got %0d", want.strain, got.strain);
                  fail_count++;
               end
               if (got.segment !== want.segment) begin
                  $error("segment_out: expected %0d, got %0d", want.segment, got.segment);
                  fail_count++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            if (csr_index < CSR_STRESS_1)
               brk_strain[csr_index[1:0]] = csr_data;
            else if (csr_index < CSR_END)
               brk_stress[csr_index[1:0]] = csr_data;
         end
         if (req_tvalid && req_tready) begin
            case (req_tuser)
               OP_TRIAL:  take_strain(longint'($signed(req_tdata)));
               OP_COMMIT: commit_state();
               OP_REVERT: begin
                  cur_strain = held_strain;
                  cur_stress = held_stress;
                  cur_tangent = held_tangent;
               end
               default:   build_table();
            endcase
            want.stress  = cur_stress[31:0];
            want.tangent = cur_tangent[31:0];
            want.strain  = cur_strain[31:0];
            want.segment = cur_seg[1:0];
            expected_words.push_back(want);
         end
      end
      pending = expected_words.size();
   end

endmodule

// ===== tb/tb_multilinear_hysteretic_material.sv =====
`timescale 1ns / 1ps

module tb_multilinear_hysteretic_material;
   import mhm_pkg::*;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [31:0]  req_tdata = '0;
   logic [1:0]   req_tuser = OP_TRIAL;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [103:0] rsp_tdata;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [3:0]   csr_index = '0;
   logic [30:0]  csr_data = '0;
   int           fail_count;
   int           pending;
   int           cycle_count = 0;
   int           words_taken = 0;
   logic [31:0]  last_strain = '0;
   logic [30:0]  top_strain = 31'd262144;

   always #5 clock = ~clock;

   multilinear_hysteretic_material dut (.*);

   mhm_checker checker_i (.*);

   // quiet window: no random gaps on either side
   function automatic logic take_gap();
      return cycle_count > 3000 && cycle_count < 9000 ? 1'b0 : $urandom_range(99) < 6;
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (rsp_tvalid && rsp_tready) words_taken <= words_taken + 1;
      if (cycle_count > 600000) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // receiver, with a long hold-off once forty words are taken, to back the block up
   initial begin
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         if (words_taken == 40) begin
            rsp_tready <= 1'b0;
            repeat (400) @(negedge clock);
         end
         rsp_tready <= !take_gap();
      end
   end

   task automatic send(input logic [1:0] op, input logic [31:0] strain);
      @(negedge clock);
      while (take_gap()) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= strain;
      if (op == OP_TRIAL) last_strain = strain;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic write_reg(input logic [3:0] idx, input logic [30:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   // quiesce, load a breakpoint set and rebuild the table
   task automatic load_points(input logic [30:0] e [4], input logic [30:0] s [4]);
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      top_strain = '0;
      for (int i = 0; i < 4; i++) begin
         write_reg(4'(CSR_STRAIN_1 + i), e[i]);
         write_reg(4'(CSR_STRESS_1 + i), s[i]);
         if (e[i] > top_strain) top_strain = e[i];
      end
      write_reg(CSR_END, 31'($urandom()));
      @(negedge clock);
      csr_valid <= 1'b0;
      send(OP_START, $urandom());
   endtask

   function automatic logic [31:0] pick_strain();
      int     r;
      longint reach;
      r = $urandom_range(99);
      reach = longint'(top_strain) * 3;
      if (reach > 64'd2147483647) reach = 64'd2147483647;
      if (reach < 4) reach = 4;
      if (r < 12) return $urandom();
      if (r < 22) return last_strain;
      if ($urandom_range(1)) return -$signed(32'($urandom_range(0, int'(reach))));
      return 32'($urandom_range(0, int'(reach)));
   endfunction

   task automatic random_run(input int n);
      int r;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(99);
         if (r < 65) send(OP_TRIAL, pick_strain());
         else if (r < 85) send(OP_COMMIT, $urandom());
         else if (r < 97) send(OP_REVERT, $urandom());
         else send(OP_START, $urandom());
      end
   endtask

   initial begin
      logic [30:0] e [4];
      logic [30:0] s [4];
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: elastic, exact yield, both far sides, unchanged strain, reverts
      send(OP_TRIAL, 32'h0);
      send(OP_TRIAL, 32'h0001_0000);
      send(OP_TRIAL, 32'h0001_8000);
      send(OP_COMMIT, 32'h0);
      send(OP_TRIAL, 32'h0001_8000);
      send(OP_TRIAL, 32'h7fff_ffff);
      send(OP_COMMIT, 32'h0);
      send(OP_TRIAL, 32'h8000_0000);
      send(OP_TRIAL, 32'hffff_ffff);
      send(OP_REVERT, 32'h0);
      send(OP_TRIAL, 32'hfffc_0000);
      send(OP_COMMIT, 32'hffff_ffff);
      send(OP_TRIAL, 32'h0000_0001);
      send(OP_TRIAL, 32'h0003_4000);
      send(OP_COMMIT, 32'h0);
      send(OP_REVERT, 32'h0);
      send(OP_START, 32'h0);
      send(OP_TRIAL, 32'hfffe_8000);
      send(OP_COMMIT, 32'h0);
      random_run(150);

      // extremes: tiny strains, full-scale stresses
      e = '{31'd1, 31'd2, 31'd3, 31'h7fffffff};
      s = '{31'd0, 31'h7fffffff, 31'd5, 31'h7fffffff};
      load_points(e, s);
      random_run(130);

      // flat and repeated breakpoints
      e = '{31'd0, 31'd65536, 31'd65536, 31'd131072};
      s = '{31'd0, 31'd0, 31'd655360, 31'd655360};
      load_points(e, s);
      random_run(130);

      // unordered, random magnitude
      for (int i = 0; i < 4; i++) begin
         e[i] = 31'($urandom());
         s[i] = 31'($urandom());
      end
      load_points(e, s);
      random_run(130);

      // well-ordered random curve
      e[0] = 31'($urandom_range(1, 200000));
      s[0] = 31'($urandom_range(0, 2000000));
      for (int i = 1; i < 4; i++) begin
         e[i] = 31'(e[i-1] + $urandom_range(1, 200000));
         s[i] = 31'(s[i-1] + $urandom_range(0, 500000));
      end
      load_points(e, s);
      random_run(180);

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (50) @(negedge clock);
      if (fail_count == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/mhm_pkg.sv
hdl/multilinear_hysteretic_material.sv
tb/mhm_checker.sv
tb/tb_multilinear_hysteretic_material.sv
